// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the 3x3 inverse core. They are empty when SYNTH
// is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked only outside reset
`define MI3_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define MI3_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MI3_ASSERT(label, clk, rst, prop, msg)
`define MI3_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/mi3_pkg.sv -----
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants of the 3x3 inverse core.
// ----------------------------------------------------------------------------
package mi3_pkg;
   localparam int NUM_ELEMS = 9;
   localparam int THR_WIDTH = 31;
   typedef logic [THR_WIDTH-1:0] thr_type;
   localparam thr_type THR_RESET = thr_type'(1);
endpackage

// ----- hw/rtl/mi3_channels.sv -----
// ----------------------------------------------------------------------------
// mi3_channels
// Valid/ready channels: request word (matrix) and response word (inverse).
// ----------------------------------------------------------------------------
interface mi3_req_if #(parameter int ELEM_WIDTH = 32) ();
   logic valid;
   logic ready;
   logic signed [ELEM_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
   modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   input ready);
   modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                 output ready);
endinterface

interface mi3_rsp_if #(parameter int ELEM_WIDTH = 32) ();
   logic valid;
   logic ready;
   logic signed [ELEM_WIDTH-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
   logic singular;
   modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                   singular, input ready);
   modport sink (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                 singular, output ready);
endinterface

// ----- hw/rtl/matrix3_inverse_core.sv -----
// Pipeline: ELEM_WIDTH + 6 register stages: 2 cofactor, 3 determinant,
// ELEM_WIDTH divider stages and the response reg.
// Throughput: one word per cycle; every stage stalls only when its
// successor is full, so bubbles are squeezed out under backpressure.
// Reset: synchronous; clears all stage valid bits, threshold returns to 1.
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// Streaming 3x3 inverse of signed fixed-point matrices by the adjugate
// method, with a programmable singular threshold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix3_inverse_core #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  mi3_pkg::thr_type csr_wdata,
   mi3_req_if.sink req,
   mi3_rsp_if.source rsp
);
   import mi3_pkg::*;

   localparam int CW = 2 * ELEM_WIDTH + 1;
   localparam int DW = 3 * ELEM_WIDTH + 3;
   localparam int NW = CW + 2 * FRAC_BITS;

   // Q.FRAC_BITS threshold magnitude; user writes only while idle, unchecked
   thr_type thr_ff, thr_in;

   // cofactor -> determinant
   logic cof_valid, cof_ready;
   logic signed [ELEM_WIDTH-1:0] row0 [3];
   logic signed [CW-1:0] cof [NUM_ELEMS];

   // determinant -> divider
   logic det_valid, det_ready;
   logic [NW-1:0] num [NUM_ELEMS];
   logic neg [NUM_ELEMS];
   logic [DW-1:0] adet;
   logic singular;

   logic [ELEM_WIDTH-1:0] any_b;

   assign thr_in = csr_we ? csr_wdata : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // stages 1-2: minor products and cofactors
   mi3_cof #(.ELEM_WIDTH(ELEM_WIDTH)) u_cof (
      .clock(clock), .reset(reset), .req(req),
      .out_valid(cof_valid), .out_ready(cof_ready),
      .row0(row0), .cof(cof)
   );

   // stages 3-5: determinant, singular test, numerators
   mi3_det #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_det (
      .clock(clock), .reset(reset),
      .in_valid(cof_valid), .in_ready(cof_ready),
      .row0(row0), .cof(cof), .thr(thr_ff),
      .out_valid(det_valid), .out_ready(det_ready),
      .num(num), .neg(neg), .adet(adet), .singular(singular)
   );

   // bit-per-stage division and response register
   mi3_div #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset),
      .in_valid(det_valid), .in_ready(det_ready),
      .num(num), .neg(neg), .adet(adet), .singular(singular),
      .rsp(rsp)
   );

   assign any_b = rsp.b00 | rsp.b01 | rsp.b02 | rsp.b10 | rsp.b11 | rsp.b12
                | rsp.b20 | rsp.b21 | rsp.b22;

   `MI3_ASSERT(a_singular_zero, clock, reset, rsp.valid && rsp.singular |-> any_b == '0, "singular word carries nonzero elements")
   `MI3_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp.valid, "response valid after reset")
endmodule

// ----- hw/rtl/mi3_cof.sv -----
// ----------------------------------------------------------------------------
// mi3_cof
// Two stages: 2x2 minor products, then signed cofactors.
// ----------------------------------------------------------------------------
module mi3_cof #(
   parameter int ELEM_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   mi3_req_if.sink req,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [ELEM_WIDTH-1:0] row0 [3],
   output logic signed [2*ELEM_WIDTH:0] cof [mi3_pkg::NUM_ELEMS]
);
   import mi3_pkg::*;

   localparam int PW = 2 * ELEM_WIDTH;
   localparam int CW = PW + 1;

   logic signed [ELEM_WIDTH-1:0] m [NUM_ELEMS];
   logic signed [PW-1:0] pa_in [NUM_ELEMS];
   logic signed [PW-1:0] pb_in [NUM_ELEMS];
   logic signed [PW-1:0] pa_ff [NUM_ELEMS];
   logic signed [PW-1:0] pb_ff [NUM_ELEMS];
   logic signed [CW-1:0] cof_in [NUM_ELEMS];
   logic signed [CW-1:0] cof_ff [NUM_ELEMS];
   logic signed [ELEM_WIDTH-1:0] r1_ff [3];
   logic signed [ELEM_WIDTH-1:0] r2_ff [3];
   logic v1_ff, v1_in, v2_ff, v2_in;
   logic en1, en2;

   always_comb begin
      m[0] = req.a00; m[1] = req.a01; m[2] = req.a02;
      m[3] = req.a10; m[4] = req.a11; m[5] = req.a12;
      m[6] = req.a20; m[7] = req.a21; m[8] = req.a22;
   end

   assign en2 = !v2_ff || out_ready;
   assign en1 = !v1_ff || en2;
   assign req.ready = en1;
   assign v1_in = en1 ? req.valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;

   for (genvar gi = 0; gi < 3; gi++) begin : g_row
      for (genvar gj = 0; gj < 3; gj++) begin : g_col
         localparam int R0 = (gi == 0) ? 1 : 0;
         localparam int R1 = (gi == 2) ? 1 : 2;
         localparam int C0 = (gj == 0) ? 1 : 0;
         localparam int C1 = (gj == 2) ? 1 : 2;
         localparam int IX = gi * 3 + gj;
         assign pa_in[IX] = PW'(m[R0*3+C0]) * PW'(m[R1*3+C1]);
         assign pb_in[IX] = PW'(m[R0*3+C1]) * PW'(m[R1*3+C0]);
         if (((gi + gj) % 2) == 1) begin : g_neg
            assign cof_in[IX] = CW'(pb_ff[IX]) - CW'(pa_ff[IX]);
         end else begin : g_pos
            assign cof_in[IX] = CW'(pa_ff[IX]) - CW'(pb_ff[IX]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         r1_ff <= m[0:2];
      end
      if (en2) begin
         cof_ff <= cof_in;
         r2_ff <= r1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign row0 = r2_ff;
   assign cof = cof_ff;
endmodule

// ----- hw/rtl/mi3_det.sv -----
// ----------------------------------------------------------------------------
// mi3_det
// Three stages: determinant partial products, sum, then magnitude,
// singular test and scaled adjugate numerators.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mi3_det #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [ELEM_WIDTH-1:0] row0 [3],
   input  logic signed [2*ELEM_WIDTH:0] cof [mi3_pkg::NUM_ELEMS],
   input  mi3_pkg::thr_type thr,
   output logic out_valid,
   input  logic out_ready,
   output logic [2*ELEM_WIDTH+2*FRAC_BITS:0] num [mi3_pkg::NUM_ELEMS],
   output logic neg [mi3_pkg::NUM_ELEMS],
   output logic [3*ELEM_WIDTH+2:0] adet,
   output logic singular
);
   import mi3_pkg::*;

   localparam int EW = ELEM_WIDTH;
   localparam int CW = 2 * EW + 1;
   localparam int PPW = 2 * EW + 1;
   localparam int DW = 3 * EW + 3;
   localparam int NW = CW + 2 * FRAC_BITS;
   localparam int TW = THR_WIDTH + 2 * FRAC_BITS;
   localparam int CMPW = (DW > TW) ? DW : TW;

   logic signed [PPW-1:0] plo_in [3];
   logic signed [PPW-1:0] phi_in [3];
   logic signed [PPW-1:0] plo_ff [3];
   logic signed [PPW-1:0] phi_ff [3];
   logic signed [CW-1:0] cof3_ff [NUM_ELEMS];
   logic signed [CW-1:0] cof4_ff [NUM_ELEMS];
   logic signed [DW-1:0] det_in, det_ff;
   logic [CW-1:0] mag [NUM_ELEMS];
   logic [NW-1:0] num_in [NUM_ELEMS];
   logic [NW-1:0] num_ff [NUM_ELEMS];
   logic neg_in [NUM_ELEMS];
   logic neg_ff [NUM_ELEMS];
   logic [DW-1:0] adet_in, adet_ff;
   logic sing_in, sing_ff;
   logic det_neg;
   logic v3_ff, v3_in, v4_ff, v4_in, v5_ff, v5_in;
   logic en3, en4, en5;

   assign en5 = !v5_ff || out_ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign in_ready = en3;
   assign v3_in = en3 ? in_valid : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;
   assign v5_in = en5 ? v4_ff : v5_ff;

   // row-0 expansion; cofactor split into low (unsigned) and high halves
   for (genvar gj = 0; gj < 3; gj++) begin : g_pp
      assign plo_in[gj] = PPW'(row0[gj]) * PPW'($signed({1'b0, cof[gj][EW-1:0]}));
      assign phi_in[gj] = PPW'(row0[gj]) * PPW'($signed(cof[gj][CW-1:EW]));
   end

   assign det_in = (DW'(phi_ff[0]) <<< EW) + DW'(plo_ff[0])
                 + (DW'(phi_ff[1]) <<< EW) + DW'(plo_ff[1])
                 + (DW'(phi_ff[2]) <<< EW) + DW'(plo_ff[2]);

   assign det_neg = det_ff[DW-1];
   assign adet_in = det_neg ? DW'(-det_ff) : DW'(det_ff);
   assign sing_in = (det_ff == '0) ||
                    (CMPW'(adet_in) < (CMPW'(thr) << (2 * FRAC_BITS)));

   for (genvar gi = 0; gi < 3; gi++) begin : g_out_row
      for (genvar gj = 0; gj < 3; gj++) begin : g_out_col
         // result (i,j) takes the transposed cofactor (j,i)
         localparam int OX = gi * 3 + gj;
         localparam int CX = gj * 3 + gi;
         assign mag[OX] = cof4_ff[CX][CW-1] ? CW'(-cof4_ff[CX]) : CW'(cof4_ff[CX]);
         assign num_in[OX] = NW'(mag[OX]) << (2 * FRAC_BITS);
         assign neg_in[OX] = cof4_ff[CX][CW-1] ^ det_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         cof3_ff <= cof;
      end
      if (en4) begin
         det_ff <= det_in;
         cof4_ff <= cof3_ff;
      end
      if (en5) begin
         num_ff <= num_in;
         neg_ff <= neg_in;
         adet_ff <= adet_in;
         sing_ff <= sing_in;
      end
   end

   assign out_valid = v5_ff;
   assign num = num_ff;
   assign neg = neg_ff;
   assign adet = adet_ff;
   assign singular = sing_ff;

   `MI3_ASSERT(a_zero_det_singular, clock, reset, v4_ff && en5 && (det_ff == '0) |=> v5_ff && sing_ff, "zero determinant not flagged singular")
endmodule

// ----- hw/rtl/mi3_div.sv -----
// ----------------------------------------------------------------------------
// mi3_div
// Nine restoring dividers in lockstep: an overflow test stage, then one quotient
// bit per stage, then sign, saturation and the response register.
// ----------------------------------------------------------------------------
module mi3_div #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [2*ELEM_WIDTH+2*FRAC_BITS:0] num [mi3_pkg::NUM_ELEMS],
   input  logic neg [mi3_pkg::NUM_ELEMS],
   input  logic [3*ELEM_WIDTH+2:0] adet,
   input  logic singular,
   mi3_rsp_if.source rsp
);
   import mi3_pkg::*;

   localparam int EW = ELEM_WIDTH;
   localparam int NW = 2 * EW + 2 * FRAC_BITS + 1;
   localparam int DW = 3 * EW + 3;
   localparam int RW = (NW > DW + EW - 1) ? NW : DW + EW - 1;
   localparam int QW = EW - 1;
   localparam int NS = EW;

   logic [RW-1:0] rem_ff [NS][NUM_ELEMS];
   logic [RW-1:0] rem_in [NS][NUM_ELEMS];
   logic [RW-1:0] src_rem [NS][NUM_ELEMS];
   logic [QW-1:0] q_ff [NS][NUM_ELEMS];
   logic [QW-1:0] q_in [NS][NUM_ELEMS];
   logic [QW-1:0] src_q [NS][NUM_ELEMS];
   logic sat_ff [NS][NUM_ELEMS];
   logic sat_in [NS][NUM_ELEMS];
   logic src_sat [NS][NUM_ELEMS];
   logic neg_ff [NS][NUM_ELEMS];
   logic src_neg [NS][NUM_ELEMS];
   logic [DW-1:0] adet_ff [NS];
   logic [DW-1:0] src_adet [NS];
   logic sing_ff [NS];
   logic src_sing [NS];
   logic v_ff [NS];
   logic v_in [NS];
   logic src_v [NS];
   logic en [NS+1];

   logic signed [EW-1:0] b_in [NUM_ELEMS];
   logic signed [EW-1:0] b_ff [NUM_ELEMS];
   logic osing_ff, ov_ff, ov_in;

   assign en[NS] = !ov_ff || rsp.ready;
   assign in_ready = en[0];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      // stage 0 tests for overflow; stage s > 0 resolves quotient bit K
      localparam int K = (s == 0) ? EW - 1 : EW - 1 - s;

      assign en[s] = !v_ff[s] || en[s+1];
      assign v_in[s] = en[s] ? src_v[s] : v_ff[s];

      if (s == 0) begin : g_src_in
         assign src_v[s] = in_valid;
         assign src_adet[s] = adet;
         assign src_sing[s] = singular;
      end else begin : g_src_ff
         assign src_v[s] = v_ff[s-1];
         assign src_adet[s] = adet_ff[s-1];
         assign src_sing[s] = sing_ff[s-1];
      end

      for (genvar l = 0; l < NUM_ELEMS; l++) begin : g_lane
         logic [RW-1:0] trial;
         logic ge;

         if (s == 0) begin : g_lsrc_in
            assign src_rem[s][l] = RW'(num[l]);
            assign src_q[s][l] = '0;
            assign src_sat[s][l] = 1'b0;
            assign src_neg[s][l] = neg[l];
         end else begin : g_lsrc_ff
            assign src_rem[s][l] = rem_ff[s-1][l];
            assign src_q[s][l] = q_ff[s-1][l];
            assign src_sat[s][l] = sat_ff[s-1][l];
            assign src_neg[s][l] = neg_ff[s-1][l];
         end

         assign trial = RW'(src_adet[s]) << K;
         assign ge = src_rem[s][l] >= trial;

         if (s == 0) begin : g_ovf
            assign sat_in[s][l] = ge;
            assign rem_in[s][l] = src_rem[s][l];
            assign q_in[s][l] = src_q[s][l];
         end else begin : g_bit
            assign sat_in[s][l] = src_sat[s][l];
            assign rem_in[s][l] = ge ? src_rem[s][l] - trial : src_rem[s][l];
            always_comb begin
               q_in[s][l] = src_q[s][l];
               q_in[s][l][K] = ge;
            end
         end

         always_ff @(posedge clock) begin
            if (en[s]) begin
               rem_ff[s][l] <= rem_in[s][l];
               q_ff[s][l] <= q_in[s][l];
               sat_ff[s][l] <= sat_in[s][l];
               neg_ff[s][l] <= src_neg[s][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_in[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            adet_ff[s] <= src_adet[s];
            sing_ff[s] <= src_sing[s];
         end
      end
   end

   // sign, saturation and the singular zero matrix
   for (genvar l = 0; l < NUM_ELEMS; l++) begin : g_fmt
      logic [EW-1:0] qe;
      assign qe = {1'b0, q_ff[NS-1][l]};
      always_comb begin
         if (sing_ff[NS-1]) begin
            b_in[l] = '0;
         end else if (sat_ff[NS-1][l]) begin
            b_in[l] = neg_ff[NS-1][l] ? $signed({1'b1, {QW{1'b0}}})
                                      : $signed({1'b0, {QW{1'b1}}});
         end else begin
            b_in[l] = neg_ff[NS-1][l] ? $signed(-qe) : $signed(qe);
         end
      end
   end

   assign ov_in = en[NS] ? v_ff[NS-1] : ov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS]) begin
         b_ff <= b_in;
         osing_ff <= sing_ff[NS-1];
      end
   end

   assign rsp.valid = ov_ff;
   assign rsp.singular = osing_ff;
   assign rsp.b00 = b_ff[0];
   assign rsp.b01 = b_ff[1];
   assign rsp.b02 = b_ff[2];
   assign rsp.b10 = b_ff[3];
   assign rsp.b11 = b_ff[4];
   assign rsp.b12 = b_ff[5];
   assign rsp.b20 = b_ff[6];
   assign rsp.b21 = b_ff[7];
   assign rsp.b22 = b_ff[8];
endmodule

// ----- tb/tb_matrix3_inverse_core.sv -----
// ----------------------------------------------------------------------------
// tb_matrix3_inverse_core
// Self-checking bench for the streaming 3x3 inverse core. A table of directed
// matrices comes first. Random matrices follow over several threshold
// settings. Every accepted request is run through a wide-integer adjugate
// predictor, and each response word is checked against the oldest
// prediction. Both channels idle at random, and one long response stall
// fills the pipe.
// ----------------------------------------------------------------------------
module tb_matrix3_inverse_core;
   import mi3_pkg::*;

   typedef logic signed [31:0] elem_type;
   typedef logic signed [199:0] wide_type;   // exact room for det and shifted cofactors

   typedef struct {
      elem_type b [NUM_ELEMS];
      logic     singular;
   } inverse_type;

   typedef struct {
      elem_type    a [NUM_ELEMS];
      logic        exact;                    // expected value typed in below
      inverse_type want;
   } directed_row_type;

   localparam elem_type ONE = 32'sh0001_0000;
   localparam elem_type SAT_POS = 32'sh7FFF_FFFF;
   localparam elem_type SAT_NEG = 32'sh8000_0000;
   localparam int PIPE_LATENCY = 38;
   localparam int ITEMS_PER_PHASE = 255;
   localparam int NUM_PHASES = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   thr_type csr_wdata = '0;

   mi3_req_if #(.ELEM_WIDTH(32)) req_ch ();
   mi3_rsp_if #(.ELEM_WIDTH(32)) rsp_ch ();

   matrix3_inverse_core #(.ELEM_WIDTH(32), .FRAC_BITS(16)) u_top (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the threshold register, updated on the write edge.
   thr_type thr_shadow = THR_RESET;
   inverse_type expected_inverses [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_seq = 0;            // bumped by stimulus to ask for one long stall

   // ---------------------------------------------------------------------------
   // Predictor: adjugate over determinant, exact in 200-bit signed integers.
   // Cofactors carry 32 fraction bits and the determinant 48, so
   // b = (cof << 32) / det lands back in Q16.16.
   // ---------------------------------------------------------------------------
   function automatic inverse_type invert_matrix(elem_type a [NUM_ELEMS], thr_type thr);
      wide_type m [NUM_ELEMS];
      wide_type cof [NUM_ELEMS];
      wide_type det, adet, num, quo, cofv;
      int r0, r1, c0, c1;
      logic neg;
      inverse_type res;
      for (int k = 0; k < NUM_ELEMS; k++) m[k] = wide_type'(a[k]);
      for (int i = 0; i < 3; i++) begin
         r0 = (i == 0) ? 1 : 0;
         r1 = (i == 2) ? 1 : 2;
         for (int j = 0; j < 3; j++) begin
            c0 = (j == 0) ? 1 : 0;
            c1 = (j == 2) ? 1 : 2;
            cof[i*3+j] = m[r0*3+c0] * m[r1*3+c1] - m[r0*3+c1] * m[r1*3+c0];
            if ((i + j) % 2 == 1) cof[i*3+j] = -cof[i*3+j];
         end
      end
      det = m[0] * cof[0] + m[1] * cof[1] + m[2] * cof[2];
      adet = (det < 0) ? -det : det;
      // det of zero is singular even when the threshold is zero
      if (det == 0 || adet < (wide_type'(thr) <<< 32)) begin
         foreach (res.b[k]) res.b[k] = '0;
         res.singular = 1'b1;
         return res;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cofv = cof[j*3+i];            // transpose: adjugate
            neg = (cofv < 0) != (det < 0);
            num = ((cofv < 0) ? -cofv : cofv) <<< 32;
            quo = num / adet;             // both positive: truncation toward zero
            if (quo >= (wide_type'(1) <<< 31))
               res.b[i*3+j] = neg ? SAT_NEG : SAT_POS;
            else
               res.b[i*3+j] = neg ? -elem_type'(quo[31:0]) : elem_type'(quo[31:0]);
         end
      end
      res.singular = 1'b0;
      return res;
   endfunction

   function automatic logic inverse_matches(inverse_type want, inverse_type got);
      logic ok;
      ok = (want.singular === got.singular);
      foreach (want.b[k]) if (want.b[k] !== got.b[k]) ok = 1'b0;
      return ok;
   endfunction

   function automatic void report_mismatch(string what, inverse_type want, inverse_type got);
      errors++;
      if (errors <= 10) begin
         $display("MISMATCH %s at %0t", what, $realtime);
         foreach (want.b[k])
            if (want.b[k] !== got.b[k])
               $display("  b%0d%0d: expected %h got %h", k / 3, k % 3, want.b[k], got.b[k]);
         if (want.singular !== got.singular)
            $display("  singular: expected %b got %b", want.singular, got.singular);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: predict on request accept, check on response accept.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      elem_type    req_word [NUM_ELEMS];
      inverse_type got, want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            req_word = '{req_ch.a00, req_ch.a01, req_ch.a02,
                         req_ch.a10, req_ch.a11, req_ch.a12,
                         req_ch.a20, req_ch.a21, req_ch.a22};
            expected_inverses.push_back(invert_matrix(req_word, thr_shadow));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.b = '{rsp_ch.b00, rsp_ch.b01, rsp_ch.b02,
                      rsp_ch.b10, rsp_ch.b11, rsp_ch.b12,
                      rsp_ch.b20, rsp_ch.b21, rsp_ch.b22};
            got.singular = rsp_ch.singular;
            if (expected_inverses.size() == 0) begin
               foreach (want.b[k]) want.b[k] = 'x;
               want.singular = 1'bx;
               report_mismatch("unexpected response word", want, got);
            end else begin
               want = expected_inverses.pop_front();
               if (!inverse_matches(want, got)) report_mismatch("response word", want, got);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response side: random backpressure, plus a long hold-off on request.
   // ---------------------------------------------------------------------------
   int hold_cycles = 0;
   int seen_stall_seq = 0;
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_seq != seen_stall_seq) begin
         seen_stall_seq <= stall_seq;
         hold_cycles <= 400;
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------------
   initial begin
      req_ch.valid = 1'b0;
      {req_ch.a00, req_ch.a01, req_ch.a02, req_ch.a10, req_ch.a11,
       req_ch.a12, req_ch.a20, req_ch.a21, req_ch.a22} = '0;
   end

   // Offer one matrix word and hold it until accepted; random gap in front.
   task automatic send_matrix(elem_type a [NUM_ELEMS]);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.a00 <= a[0]; req_ch.a01 <= a[1]; req_ch.a02 <= a[2];
      req_ch.a10 <= a[3]; req_ch.a11 <= a[4]; req_ch.a12 <= a[5];
      req_ch.a20 <= a[6]; req_ch.a21 <= a[7]; req_ch.a22 <= a[8];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_pipe();
      while (expected_inverses.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_threshold(thr_type value);
      drain_pipe();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      thr_shadow = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random element in four flavors: full range, small Q16.16, tiny, or a most-positive/most-negative extreme.
   function automatic elem_type random_elem(int flavor);
      case (flavor)
         0: return elem_type'($urandom);
         1: return elem_type'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
         2: return elem_type'($signed($urandom_range(0, 64)) - 32);
         default: return ($urandom_range(1) != 0) ? SAT_POS : SAT_NEG;
      endcase
   endfunction

   function automatic void random_matrix(output elem_type a [NUM_ELEMS]);
      int shape, flavor;
      shape = $urandom_range(99);
      flavor = $urandom_range(2);
      for (int k = 0; k < NUM_ELEMS; k++)
         a[k] = random_elem(($urandom_range(9) == 0) ? $urandom_range(3) : flavor);
      if (shape < 30) begin
         // well conditioned: dominant diagonal of a few units
         for (int k = 0; k < NUM_ELEMS; k++) a[k] = random_elem(1) >>> 2;
         a[0] += 32'sh0004_0000; a[4] -= 32'sh0003_0000; a[8] += 32'sh0005_0000;
      end else if (shape < 45) begin
         // nearly singular: last row follows the first, with a small nudge
         for (int k = 0; k < 3; k++) a[6+k] = a[k] + random_elem(2);
      end else if (shape < 55) begin
         // diagonal with small entries: drives the quotient into saturation
         for (int k = 0; k < NUM_ELEMS; k++) a[k] = '0;
         a[0] = random_elem(2);
         a[4] = random_elem(1);
         a[8] = random_elem($urandom_range(2));
      end
   endfunction

   directed_row_type directed_rows [$];

   function automatic void add_row(elem_type a [NUM_ELEMS], logic exact,
                                   elem_type b [NUM_ELEMS], logic singular);
      directed_row_type row;
      row.a = a;
      row.exact = exact;
      row.want.b = b;
      row.want.singular = singular;
      directed_rows.push_back(row);
   endfunction

   initial begin
      elem_type    z [NUM_ELEMS];
      elem_type    mat [NUM_ELEMS];
      inverse_type want;
      thr_type     phase_thr [NUM_PHASES];

      z = '{default: '0};
      // zero matrix: singular
      add_row(z, 1'b1, z, 1'b1);
      // identity and scaled identities
      add_row('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1,
              '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b0);
      add_row('{2*ONE, 0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE}, 1'b1,
              '{ONE/2, 0, 0, 0, ONE/2, 0, 0, 0, ONE/2}, 1'b0);
      add_row('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1'b1,
              '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1'b0);
      // smallest elements: determinant under the reset threshold
      add_row('{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b1, z, 1'b1);
      // all most-negative / all most-positive: rank one
      add_row('{default: SAT_NEG}, 1'b1, z, 1'b1);
      add_row('{default: SAT_POS}, 1'b1, z, 1'b1);
      // quotient overflow, both signs
      add_row('{2, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1,
              '{SAT_POS, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b0);
      add_row('{-2, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1,
              '{SAT_NEG, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b0);
      // extremes on the diagonal, sign mixes and bit patterns: table checks the predictor only where marked exact
      add_row('{SAT_POS, 0, 0, 0, SAT_NEG, 0, 0, 0, SAT_POS}, 1'b0, z, 1'b0);
      add_row('{SAT_NEG, SAT_POS, 0, SAT_POS, SAT_NEG, 0, 0, 0, ONE}, 1'b0, z, 1'b0);
      add_row('{ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 5*ONE, 6*ONE, 0}, 1'b0, z, 1'b0);
      add_row('{32'sh0000_8000, -ONE, 7, SAT_POS, 3, -5, 11, -ONE, SAT_NEG}, 1'b0, z, 1'b0);
      add_row('{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 1'b1, z, 1'b1);
      add_row('{32'sh5555_5555, 32'shAAAA_AAAA, 0, 0, 32'sh5555_5555,
                32'shAAAA_AAAA, 32'shAAAA_AAAA, 0, 32'sh5555_5555}, 1'b0, z, 1'b0);

      phase_thr = '{THR_RESET, thr_type'(0), thr_type'(32'h7FFF_FFFF),
                    thr_type'(32'h0001_0000), thr_type'($urandom), thr_type'(1)};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, reset threshold, no idling
      foreach (directed_rows[r]) begin
         send_matrix(directed_rows[r].a);
         if (directed_rows[r].exact) begin
            want = invert_matrix(directed_rows[r].a, thr_shadow);
            if (!inverse_matches(directed_rows[r].want, want))
               report_mismatch($sformatf("directed row %0d table", r),
                               directed_rows[r].want, want);
         end
      end
      req_ch.valid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_threshold(phase_thr[p]);
         send_idle_pct = (p < 2) ? 31 : (p < 4) ? 46 : 0;
         recv_idle_pct = (p < 2) ? 46 : (p < 4) ? 31 : 0;
         // zero determinant under a zero threshold must still be singular
         if (phase_thr[p] == 0) send_matrix(z);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 2 && n == 20) stall_seq++;
            random_matrix(mat);
            send_matrix(mat);
         end
         req_ch.valid <= 1'b0;
      end

      drain_pipe();
      if (errors == 0 && expected_inverses.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
